>>> design/mtep_pkg.sv
package mtep_pkg;

   // Input transaction: one byte of a track chunk body.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       track_start;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] abs_ticks;
      logic [27:0] delta_ticks;
      logic [3:0]  message;
      logic [3:0]  chan;
      logic [6:0]  data_first;
      logic [6:0]  data_second;
      logic [23:0] tempo_us;
      logic [1:0]  error_code;
   } rsp_type;

   // Parser to result stage: one step's outcome.
   typedef struct packed {
      logic    emit;
      rsp_type data;
   } step_type;

   // Result kinds
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_TEMPO   = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd2;
   localparam logic [1:0] ERR_BAD_STATUS = 2'd3;

   // Parse phases
   localparam int unsigned PhaseW = 3;
   localparam logic [PhaseW-1:0] PH_DELTA     = 3'd0;
   localparam logic [PhaseW-1:0] PH_STATUS    = 3'd1;
   localparam logic [PhaseW-1:0] PH_DATA1     = 3'd2;
   localparam logic [PhaseW-1:0] PH_DATA2     = 3'd3;
   localparam logic [PhaseW-1:0] PH_META_TYPE = 3'd4;
   localparam logic [PhaseW-1:0] PH_META_LEN  = 3'd5;
   localparam logic [PhaseW-1:0] PH_SYSEX_LEN = 3'd6;
   localparam logic [PhaseW-1:0] PH_SKIP      = 3'd7;

   // Byte values
   localparam logic [7:0] STATUS_META     = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX_CT = 8'hF7;
   localparam logic [7:0] META_END        = 8'h2F;
   localparam logic [7:0] META_TYPE_TEMPO = 8'h51;
   localparam logic [3:0] MSG_PROGRAM     = 4'hC;
   localparam logic [3:0] MSG_PRESSURE    = 4'hD;
   localparam logic [1:0] TEMPO_BYTES     = 2'd3;

endpackage

>>> design/mtep_in_stage.sv
module mtep_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtep_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output mtep_pkg::req_type item_data
);
   import mtep_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;

   // Take a new byte when the slot is empty or is being consumed.
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            data_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

>>> design/mtep_parser.sv
module mtep_parser #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mtep_pkg::req_type  item_data,
   output mtep_pkg::step_type result
);
   import mtep_pkg::*;

   localparam int unsigned CntW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam logic [CntW:0] MaxCnt = (CntW + 1)'(MAX_LENGTH_BYTES);

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [27:0]       acc_ff, acc_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [7:0]        rs_ff, rs_in;
   logic              sv_ff, sv_in;
   logic [31:0]       tick_ff, tick_in;
   logic [27:0]       pend_ff, pend_in;
   logic [7:0]        meta_ff, meta_in;
   logic [27:0]       skip_ff, skip_in;
   logic [23:0]       tempo_ff, tempo_in;
   logic [1:0]        tidx_ff, tidx_in;
   logic [6:0]        held_ff, held_in;

   // State as seen by this byte: a track start clears everything first.
   logic [PhaseW-1:0] cur_phase;
   logic [27:0]       cur_acc, cur_pend, cur_skip;
   logic [CntW-1:0]   cur_cnt;
   logic [7:0]        cur_rs, cur_meta;
   logic              cur_sv;
   logic [31:0]       cur_tick;
   logic [23:0]       cur_tempo;
   logic [1:0]        cur_tidx;
   logic [6:0]        cur_held;

   logic [7:0]  b;
   logic [27:0] acc_shift;
   logic [CntW:0] cnt_inc;
   logic        vl_done, vl_long;
   logic [27:0] skip_dec;
   logic [1:0]  tidx_inc;
   logic [3:0]  msg;

   always_comb begin
      b = item_data.in_byte;
      if (item_data.track_start) begin
         cur_phase = PH_DELTA;
         cur_acc   = '0;
         cur_cnt   = '0;
         cur_rs    = '0;
         cur_sv    = 1'b0;
         cur_tick  = '0;
         cur_pend  = '0;
         cur_meta  = '0;
         cur_skip  = '0;
         cur_tempo = '0;
         cur_tidx  = '0;
         cur_held  = '0;
      end else begin
         cur_phase = phase_ff;
         cur_acc   = acc_ff;
         cur_cnt   = cnt_ff;
         cur_rs    = rs_ff;
         cur_sv    = sv_ff;
         cur_tick  = tick_ff;
         cur_pend  = pend_ff;
         cur_meta  = meta_ff;
         cur_skip  = skip_ff;
         cur_tempo = tempo_ff;
         cur_tidx  = tidx_ff;
         cur_held  = held_ff;
      end
   end

   // Variable-length field helpers
   assign acc_shift = {cur_acc[20:0], b[6:0]};
   assign cnt_inc   = {1'b0, cur_cnt} + (CntW + 1)'(1);
   assign vl_done   = !b[7];
   assign vl_long   = b[7] && (cnt_inc >= MaxCnt);
   assign skip_dec  = cur_skip - 28'd1;
   assign tidx_inc  = cur_tidx + 2'd1;
   assign msg       = cur_rs[7:4];

   always_comb begin
      phase_in = cur_phase;
      acc_in   = cur_acc;
      cnt_in   = cur_cnt;
      rs_in    = cur_rs;
      sv_in    = cur_sv;
      tick_in  = cur_tick;
      pend_in  = cur_pend;
      meta_in  = cur_meta;
      skip_in  = cur_skip;
      tempo_in = cur_tempo;
      tidx_in  = cur_tidx;
      held_in  = cur_held;

      result                  = '0;
      result.data.abs_ticks   = cur_tick;
      result.data.delta_ticks = cur_pend;

      case (cur_phase)
         PH_STATUS: begin
            if (b == STATUS_META) begin
               phase_in = PH_META_TYPE;
            end else if (b inside {STATUS_SYSEX, STATUS_SYSEX_CT}) begin
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_SYSEX_LEN;
            end else if (b >= STATUS_SYSEX) begin
               acc_in                 = '0;
               cnt_in                 = '0;
               phase_in               = PH_DELTA;
               result.emit            = 1'b1;
               result.data.kind       = KIND_ERROR;
               result.data.error_code = ERR_BAD_STATUS;
            end else if (b[7]) begin
               rs_in    = b;
               sv_in    = 1'b1;
               phase_in = PH_DATA1;
            end else if (!cur_sv) begin
               acc_in                 = '0;
               cnt_in                 = '0;
               phase_in               = PH_DELTA;
               result.emit            = 1'b1;
               result.data.kind       = KIND_ERROR;
               result.data.error_code = ERR_NO_RUNNING;
            end else if (msg inside {MSG_PROGRAM, MSG_PRESSURE}) begin
               phase_in                = PH_DELTA;
               result.emit             = 1'b1;
               result.data.kind        = KIND_CHANNEL;
               result.data.message     = msg;
               result.data.chan        = cur_rs[3:0];
               result.data.data_first  = b[6:0];
            end else begin
               held_in  = b[6:0];
               phase_in = PH_DATA2;
            end
         end
         PH_DATA1: begin
            if (msg inside {MSG_PROGRAM, MSG_PRESSURE}) begin
               phase_in               = PH_DELTA;
               result.emit            = 1'b1;
               result.data.kind       = KIND_CHANNEL;
               result.data.message    = msg;
               result.data.chan       = cur_rs[3:0];
               result.data.data_first = b[6:0];
            end else begin
               held_in  = b[6:0];
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            phase_in                = PH_DELTA;
            result.emit             = 1'b1;
            result.data.kind        = KIND_CHANNEL;
            result.data.message     = msg;
            result.data.chan        = cur_rs[3:0];
            result.data.data_first  = cur_held;
            result.data.data_second = b[6:0];
         end
         PH_META_TYPE: begin
            meta_in  = b;
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            acc_in = acc_shift;
            cnt_in = cnt_inc[CntW-1:0];
            if (vl_long) begin
               acc_in                 = '0;
               cnt_in                 = '0;
               phase_in               = PH_DELTA;
               result.emit            = 1'b1;
               result.data.kind       = KIND_ERROR;
               result.data.error_code = ERR_TOO_LONG;
            end else if (vl_done) begin
               acc_in   = '0;
               cnt_in   = '0;
               skip_in  = acc_shift;
               tempo_in = '0;
               tidx_in  = '0;
               phase_in = (acc_shift == 28'd0) ? PH_DELTA : PH_SKIP;
               if ((cur_phase == PH_META_LEN) && (cur_meta == META_END)) begin
                  result.emit      = 1'b1;
                  result.data.kind = KIND_END;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 28'd0) begin
               phase_in = PH_DELTA;
            end
            // Capture the first three data bytes of a tempo meta.
            if ((cur_meta == META_TYPE_TEMPO) && (cur_tidx < TEMPO_BYTES)) begin
               tempo_in = {cur_tempo[15:0], b};
               tidx_in  = tidx_inc;
               if (tidx_inc == TEMPO_BYTES) begin
                  result.emit          = 1'b1;
                  result.data.kind     = KIND_TEMPO;
                  result.data.tempo_us = {cur_tempo[15:0], b};
               end
            end
         end
         PH_DELTA: begin
            acc_in = acc_shift;
            cnt_in = cnt_inc[CntW-1:0];
            if (vl_long) begin
               acc_in                 = '0;
               cnt_in                 = '0;
               result.emit            = 1'b1;
               result.data.kind       = KIND_ERROR;
               result.data.error_code = ERR_TOO_LONG;
            end else if (vl_done) begin
               pend_in  = acc_shift;
               tick_in  = cur_tick + {4'd0, acc_shift};
               acc_in   = '0;
               cnt_in   = '0;
               meta_in  = '0;
               phase_in = PH_STATUS;
            end
         end
         default: begin
            phase_in = PH_DELTA;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         rs_ff    <= '0;
         sv_ff    <= 1'b0;
         tick_ff  <= '0;
         pend_ff  <= '0;
         meta_ff  <= '0;
         skip_ff  <= '0;
         tempo_ff <= '0;
         tidx_ff  <= '0;
         held_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         rs_ff    <= rs_in;
         sv_ff    <= sv_in;
         tick_ff  <= tick_in;
         pend_ff  <= pend_in;
         meta_ff  <= meta_in;
         skip_ff  <= skip_in;
         tempo_ff <= tempo_in;
         tidx_ff  <= tidx_in;
         held_ff  <= held_in;
      end
   end

endmodule

>>> design/mtep_out_stage.sv
module mtep_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  mtep_pkg::step_type result,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtep_pkg::rsp_type  rsp_data
);
   import mtep_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // The register is free when empty or when its transaction leaves now.
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = step && result.emit;
         if (step && result.emit) begin
            data_in = result.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> design/midi_track_event_parser_top.sv
// Path: a byte is held in the input register and parsed there by the parse step; the result
//   transaction it completes is registered in the result register and offered from there.
// Throughput: one byte per cycle, set by the single parse step between the two registers;
//   a stalled result holds the parser and, once the input register is full, the input.
// Reset: synchronous, active high; clears both valid flags and all parse state
//   (tick time, running status, length and skip progress).
module midi_track_event_parser_top #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtep_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtep_pkg::rsp_type rsp_data
);
   import mtep_pkg::*;

   logic     item_valid;
   req_type  item_data;
   logic     out_ready;
   logic     step;
   step_type result;

   // Advance a byte through the parser whenever the result register can take
   // whatever it yields. Most bytes yield nothing, but a conservative gate on
   // out_ready keeps the parse state and the result register in lockstep.
   assign step = item_valid && out_ready;

   // Input register: holds one byte; refills in the cycle it is consumed.
   mtep_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (out_ready),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   // Parse state and the one-byte step: delta decode, running status,
   // meta and sysex lengths, skip count and tempo capture.
   mtep_parser #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_data (item_data),
      .result    (result)
   );

   // Result register: while it holds a stalled transaction, hold every byte
   // in the input register, even one that would yield nothing.
   mtep_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/mtep_checker.sv
module mtep_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mtep_pkg::rsp_type  rsp_data
);
   import mtep_pkg::*;

   // A stalled result transaction stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A stalled result transaction keeps its payload.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Error code is set exactly on error results.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_ERROR) == (rsp_data.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // Channel fields are zero outside channel events.
   a_chan_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_CHANNEL) |->
         (rsp_data.message == 4'd0) && (rsp_data.chan == 4'd0) &&
         (rsp_data.data_first == 7'd0) && (rsp_data.data_second == 7'd0))
      else $error("channel fields set on a non-channel result");

   // Tempo is zero outside tempo results.
   a_tempo_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_TEMPO) |-> (rsp_data.tempo_us == 24'd0))
      else $error("tempo set on a non-tempo result");

endmodule

bind midi_track_event_parser_top mtep_checker u_checker (.*);
